// ===== hw/rtl/npts_pkg.sv =====
// ----------------------------------------------------------------------------
// npts_pkg
// Shared types and constants for the nearest point to segment search.
// ----------------------------------------------------------------------------
package npts_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_POINT_COUNT  = 2'd0;
    localparam logic [1:0] REG_SEARCH_LIMIT = 2'd1;

    localparam logic [30:0] DEFAULT_LIMIT = 31'd100000;

    // Widest stored index the tags carry
    localparam int IDX_BITS = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP1,
        ST_SETUP2,
        ST_SETUP3,
        ST_SEED,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } npts_state_t;

    // Item tag that travels with every entry of the distance pipeline
    typedef struct packed {
        logic                  valid;
        logic                  init;
        logic [IDX_BITS-1:0]   index;
        logic signed [31:0]    x;
        logic signed [31:0]    y;
    } npts_tag_t;

endpackage

// ===== hw/rtl/npts_mac_cell.sv =====
// ----------------------------------------------------------------------------
// npts_mac_cell
// One cell of the 64x64 multiplier chain: adds one 32x32 partial product
// into the running sum and hands operands and sum to the next cell.
// ----------------------------------------------------------------------------
module npts_mac_cell #(
    parameter int STEP = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  npts_pkg::npts_tag_t in_tag,
    input  logic [63:0]         in_m,
    input  logic [63:0]         in_k,
    input  logic [127:0]        in_acc,
    output npts_pkg::npts_tag_t out_tag,
    output logic [63:0]         out_m,
    output logic [63:0]         out_k,
    output logic [127:0]        out_acc
);

    localparam int MI    = STEP / 2;
    localparam int KI    = STEP % 2;
    localparam int SHIFT = 32 * (MI + KI);

    logic [31:0]  m_half;
    logic [31:0]  k_half;
    logic [63:0]  pp;
    logic [127:0] acc_next;
    logic         valid_reg;
    npts_pkg::npts_tag_t tag_reg;

    // Pick the halves of this cell and accumulate
    assign m_half   = in_m[32*MI +: 32];
    assign k_half   = in_k[32*KI +: 32];
    assign pp       = m_half * k_half;
    assign acc_next = in_acc + (128'(pp) << SHIFT);

    // Hold the valid bit under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_tag.valid;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        tag_reg <= in_tag;
        out_m   <= in_m;
        out_k   <= in_k;
        out_acc <= acc_next;
    end

    always_comb
    begin
        out_tag       = tag_reg;
        out_tag.valid = valid_reg;
    end

endmodule

// ===== hw/rtl/nearest_point_to_segment.sv =====
// ----------------------------------------------------------------------------
// nearest_point_to_segment
// Sequence: with N = point_count capped at MAX_POINTS, a query accepted
// in idle runs the setup states SETUP1 to SETUP3 and SEED, N store reads,
// the 8 pipeline stages, then drain and finish, which loads the output; a
// stalled result holds the next query in the finish state. Throughput: one
// point per cycle, set by the single read port of the store; the next item is
// taken only once the block is back in idle, and load items are taken only
// in idle. Reset clears control and configuration (point_count 0, search_limit
// 100000); the point store is not cleared.
// Finds the first stored point nearest to a segment using exact squared
// distances scaled by the squared segment length.
// ----------------------------------------------------------------------------
module nearest_point_to_segment #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 31
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  kind,
    input  logic [9:0]            slot,
    input  logic [COORD_BITS-1:0] first_x,
    input  logic [COORD_BITS-1:0] first_y,
    input  logic [COORD_BITS-1:0] second_x,
    input  logic [COORD_BITS-1:0] second_y,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [9:0]            nearest_index,
    output logic [COORD_BITS-1:0] nearest_x,
    output logic [COORD_BITS-1:0] nearest_y,
    output logic                  found,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [30:0]           cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int NCELLS = 4;

    function automatic logic signed [31:0] sext(input logic [COORD_BITS-1:0] v);
        return {{(32 - COORD_BITS){v[COORD_BITS-1]}}, v};
    endfunction

    npts_pkg::npts_state_t state_reg, state_next;

    logic [10:0] point_count_reg;
    logic [30:0] search_limit_reg;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] cnt_reg;
    logic signed [31:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [31:0] dx_reg, dy_reg;
    logic signed [63:0] sqdx_reg, sqdy_reg;
    logic [63:0] len2_reg;
    logic [61:0] lim_sq_reg;
    logic [61:0] lim_sq_c;

    logic accept, query_accept, issue, seed, finish_load, busy;
    logic [16:0] slot_wide, count_wide;
    logic [AW-1:0] slot_addr;

    logic [COORD_BITS-1:0] x_mem [MAX_POINTS];
    logic [COORD_BITS-1:0] y_mem [MAX_POINTS];

    // Stage A: store read
    logic                  rd_valid_reg;
    logic [COORD_BITS-1:0] rd_x_reg, rd_y_reg;
    logic [npts_pkg::IDX_BITS-1:0] rd_idx_reg;

    // Stage B: differences
    npts_pkg::npts_tag_t b_tag_reg;
    logic signed [31:0] qx_reg, qy_reg, rx_reg, ry_reg;

    // Stage C: products
    npts_pkg::npts_tag_t c_tag_reg;
    logic signed [63:0] p_qxdx_reg, p_qydy_reg, p_qxdy_reg, p_qydx_reg;
    logic signed [63:0] s_qx_reg, s_qy_reg, s_rx_reg, s_ry_reg;

    // Stage D: select multiplier operands
    npts_pkg::npts_tag_t d_tag_next, d_tag_reg;
    logic [63:0] d_m_next, d_k_next, d_m_reg, d_k_reg;
    logic signed [64:0] dot_c, cross_c;
    logic [64:0] cross_mag_c;
    logic [63:0] dist_a_c, dist_b_c;

    // Cell chain
    npts_pkg::npts_tag_t tag_chain [NCELLS+1];
    logic [63:0]  m_chain   [NCELLS+1];
    logic [63:0]  k_chain   [NCELLS+1];
    logic [127:0] acc_chain [NCELLS+1];

    // Running minimum
    logic [127:0] best_reg;
    logic         best_found_reg;
    logic [npts_pkg::IDX_BITS-1:0] best_idx_reg;
    logic signed [31:0] best_x_reg, best_y_reg;

    // Output register
    logic                  out_valid_reg;
    logic [9:0]            out_index_reg;
    logic [COORD_BITS-1:0] out_x_reg, out_y_reg;
    logic                  out_found_reg;

    assign accept       = in_valid && in_ready;
    assign query_accept = accept && kind;
    assign slot_wide    = 17'(slot);
    assign slot_addr    = slot_wide[AW-1:0];
    assign count_wide   = (17'(point_count_reg) > 17'(MAX_POINTS)) ?
                          17'(MAX_POINTS) : 17'(point_count_reg);
    assign lim_sq_c     = search_limit_reg * search_limit_reg;
    assign cfg_ready    = 1'b1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            npts_pkg::ST_IDLE:   if (query_accept) state_next = npts_pkg::ST_SETUP1;
            npts_pkg::ST_SETUP1: state_next = npts_pkg::ST_SETUP2;
            npts_pkg::ST_SETUP2: state_next = npts_pkg::ST_SETUP3;
            npts_pkg::ST_SETUP3: state_next = npts_pkg::ST_SEED;
            npts_pkg::ST_SEED:   state_next = npts_pkg::ST_SCAN;
            npts_pkg::ST_SCAN:   if (cnt_reg >= count_reg) state_next = npts_pkg::ST_DRAIN;
            npts_pkg::ST_DRAIN:  if (!busy) state_next = npts_pkg::ST_FINISH;
            npts_pkg::ST_FINISH: if (finish_load) state_next = npts_pkg::ST_IDLE;
            default:             state_next = npts_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready    = (state_reg == npts_pkg::ST_IDLE);
        seed        = (state_reg == npts_pkg::ST_SEED);
        issue       = (state_reg == npts_pkg::ST_SCAN) && (cnt_reg < count_reg);
        finish_load = (state_reg == npts_pkg::ST_FINISH) && (!out_valid_reg || out_ready);
    end

    assign busy = rd_valid_reg || b_tag_reg.valid || c_tag_reg.valid || d_tag_reg.valid
                  || tag_chain[1].valid || tag_chain[2].valid
                  || tag_chain[3].valid || tag_chain[4].valid;

    // Control registers and stage tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= npts_pkg::ST_IDLE;
            point_count_reg  <= 11'd0;
            search_limit_reg <= npts_pkg::DEFAULT_LIMIT;
            cnt_reg          <= '0;
            rd_valid_reg     <= 1'b0;
            b_tag_reg        <= '0;
            c_tag_reg        <= '0;
            d_tag_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == npts_pkg::REG_POINT_COUNT)
                begin
                    point_count_reg <= cfg_data[10:0];
                end
                else if (cfg_index == npts_pkg::REG_SEARCH_LIMIT)
                begin
                    search_limit_reg <= cfg_data;
                end
            end
            if (seed)
            begin
                cnt_reg <= '0;
            end
            else if (issue)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            rd_valid_reg <= issue;
            b_tag_reg    <= '{valid: rd_valid_reg, init: 1'b0, index: rd_idx_reg,
                              x: sext(rd_x_reg), y: sext(rd_y_reg)};
            c_tag_reg    <= b_tag_reg;
            d_tag_reg    <= d_tag_next;
            if (finish_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Store write and registered read
    always_ff @(posedge clk)
    begin
        if (accept && !kind && (slot_wide < 17'(MAX_POINTS)))
        begin
            x_mem[slot_addr] <= first_x;
            y_mem[slot_addr] <= first_y;
        end
        rd_x_reg   <= x_mem[cnt_reg[AW-1:0]];
        rd_y_reg   <= y_mem[cnt_reg[AW-1:0]];
        rd_idx_reg <= npts_pkg::IDX_BITS'(cnt_reg);
    end

    // Latch the segment and derive its length
    always_ff @(posedge clk)
    begin
        if (query_accept)
        begin
            ax_reg    <= sext(first_x);
            ay_reg    <= sext(first_y);
            bx_reg    <= sext(second_x);
            by_reg    <= sext(second_y);
            count_reg <= count_wide[CW-1:0];
        end
        if (state_reg == npts_pkg::ST_SETUP1)
        begin
            dx_reg     <= bx_reg - ax_reg;
            dy_reg     <= by_reg - ay_reg;
            lim_sq_reg <= lim_sq_c;
        end
        if (state_reg == npts_pkg::ST_SETUP2)
        begin
            sqdx_reg <= dx_reg * dx_reg;
            sqdy_reg <= dy_reg * dy_reg;
        end
        if (state_reg == npts_pkg::ST_SETUP3)
        begin
            len2_reg <= 64'(sqdx_reg) + 64'(sqdy_reg);
        end
    end

    // Stages B and C payload
    always_ff @(posedge clk)
    begin
        qx_reg <= sext(rd_x_reg) - ax_reg;
        qy_reg <= sext(rd_y_reg) - ay_reg;
        rx_reg <= sext(rd_x_reg) - bx_reg;
        ry_reg <= sext(rd_y_reg) - by_reg;

        p_qxdx_reg <= qx_reg * dx_reg;
        p_qydy_reg <= qy_reg * dy_reg;
        p_qxdy_reg <= qx_reg * dy_reg;
        p_qydx_reg <= qy_reg * dx_reg;
        s_qx_reg   <= qx_reg * qx_reg;
        s_qy_reg   <= qy_reg * qy_reg;
        s_rx_reg   <= rx_reg * rx_reg;
        s_ry_reg   <= ry_reg * ry_reg;
    end

    // Choose the clamped distance form for the multiplier chain
    always_comb
    begin
        dot_c       = 65'(p_qxdx_reg) + 65'(p_qydy_reg);
        cross_c     = 65'(p_qxdy_reg) - 65'(p_qydx_reg);
        cross_mag_c = cross_c[64] ? 65'(-cross_c) : 65'(cross_c);
        dist_a_c    = 64'(s_qx_reg) + 64'(s_qy_reg);
        dist_b_c    = 64'(s_rx_reg) + 64'(s_ry_reg);
        d_tag_next  = c_tag_reg;
        if (seed)
        begin
            d_tag_next.valid = 1'b1;
            d_tag_next.init  = 1'b1;
            d_m_next = 64'(lim_sq_reg);
            d_k_next = (len2_reg == 64'd0) ? 64'd1 : len2_reg;
        end
        else if (len2_reg == 64'd0)
        begin
            d_m_next = dist_a_c;
            d_k_next = 64'd1;
        end
        else if (dot_c[64])
        begin
            d_m_next = dist_a_c;
            d_k_next = len2_reg;
        end
        else if (dot_c[63:0] > len2_reg)
        begin
            d_m_next = dist_b_c;
            d_k_next = len2_reg;
        end
        else
        begin
            d_m_next = cross_mag_c[63:0];
            d_k_next = cross_mag_c[63:0];
        end
    end

    always_ff @(posedge clk)
    begin
        d_m_reg <= d_m_next;
        d_k_reg <= d_k_next;
    end

    // Multiplier chain
    assign tag_chain[0] = d_tag_reg;
    assign m_chain[0]   = d_m_reg;
    assign k_chain[0]   = d_k_reg;
    assign acc_chain[0] = '0;

    for (genvar g = 0; g < NCELLS; g++)
    begin : g_cell
        npts_mac_cell #(.STEP(g)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_tag  (tag_chain[g]),
            .in_m    (m_chain[g]),
            .in_k    (k_chain[g]),
            .in_acc  (acc_chain[g]),
            .out_tag (tag_chain[g+1]),
            .out_m   (m_chain[g+1]),
            .out_k   (k_chain[g+1]),
            .out_acc (acc_chain[g+1])
        );
    end

    // Track the running minimum; the seed entry arrives first
    always_ff @(posedge clk)
    begin
        if (tag_chain[NCELLS].valid)
        begin
            if (tag_chain[NCELLS].init)
            begin
                best_reg       <= acc_chain[NCELLS];
                best_found_reg <= 1'b0;
            end
            else if (acc_chain[NCELLS] < best_reg)
            begin
                best_reg       <= acc_chain[NCELLS];
                best_found_reg <= 1'b1;
                best_idx_reg   <= tag_chain[NCELLS].index;
                best_x_reg     <= tag_chain[NCELLS].x;
                best_y_reg     <= tag_chain[NCELLS].y;
            end
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (finish_load)
        begin
            out_found_reg <= best_found_reg;
            out_index_reg <= best_found_reg ? best_idx_reg[9:0] : 10'd0;
            out_x_reg     <= best_found_reg ? best_x_reg[COORD_BITS-1:0] : '0;
            out_y_reg     <= best_found_reg ? best_y_reg[COORD_BITS-1:0] : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign nearest_index = out_index_reg;
    assign nearest_x     = out_x_reg;
    assign nearest_y     = out_y_reg;
    assign found         = out_found_reg;

endmodule

// ===== hw/rtl/npts_checker.sv =====
// ----------------------------------------------------------------------------
// npts_checker
// Port-level checks for the nearest point to segment block.
// ----------------------------------------------------------------------------
module npts_checker #(
    parameter int COORD_BITS = 31
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  kind,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [9:0]            nearest_index,
    input logic [COORD_BITS-1:0] nearest_x,
    input logic [COORD_BITS-1:0] nearest_y,
    input logic                  found
);

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(nearest_index) && $stable(found))
        else $error("result item changed while stalled");

    // Drop ready once a query starts
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind |=> !in_ready)
        else $error("input taken during a search");

    // Report zeros when nothing was found
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> nearest_index == 10'd0 && nearest_x == '0 && nearest_y == '0)
        else $error("nonzero fields without a match");

    // Do not raise a new result as a query is taken
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind && !(out_valid && !out_ready) |=> !$rose(out_valid))
        else $error("result item too early");

endmodule

bind nearest_point_to_segment npts_checker #(.COORD_BITS(COORD_BITS)) u_npts_checker (.*);
